// File: sv/ppe_pkg.sv
`default_nettype none

package ppe_pkg;

  // Configuration register map.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgIdxMaskLow  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxMaskHigh = 8'd1;

  localparam int unsigned MaskW = 64;
  localparam logic [MaskW-1:0] EscMaskLowReset  = 64'hA400_84AC_FFFF_FFFF;
  localparam logic [MaskW-1:0] EscMaskHighReset = 64'hA800_0000_7800_0000;

  // Depth of the command queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ErrByte   = 8'h00;

  typedef enum logic [1:0] {
    SepNone,
    SepEquals,
    SepSlash
  } sep_e;

  // One classified input byte, as handed from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       escape;
    sep_e       sep;
    logic       path_end;
    logic       error;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'h0, v};
    if (v < 4'd10) begin
      return 8'h30 + w;
    end
    return 8'h37 + w;
  endfunction

endpackage

`default_nettype wire

// File: sv/ppe_front.sv
`default_nettype none

module ppe_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        field_end_i,
  input  wire logic                        spec_end_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ppe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ppe_pkg::MaskW-1:0]   cfg_data_i,
  input  wire logic                        full_i,
  output logic                             push_o,
  output ppe_pkg::cmd_t                    cmd_o
);

  logic [ppe_pkg::MaskW-1:0] mask_low_q;
  logic [ppe_pkg::MaskW-1:0] mask_high_q;
  logic                      phase_q;
  logic                      phase_d;
  logic                      escape;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_low_q  <= ppe_pkg::EscMaskLowReset;
      mask_high_q <= ppe_pkg::EscMaskHighReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ppe_pkg::CfgIdxMaskLow) begin
        mask_low_q <= cfg_data_i;
      end else if (cfg_index_i == ppe_pkg::CfgIdxMaskHigh) begin
        mask_high_q <= cfg_data_i;
      end
    end
  end

  // Bytes 128 and up are never escaped.
  always_comb begin
    if (data_byte_i[7]) begin
      escape = 1'b0;
    end else if (data_byte_i[6]) begin
      escape = mask_high_q[data_byte_i[5:0]];
    end else begin
      escape = mask_low_q[data_byte_i[5:0]];
    end
  end

  always_comb begin
    cmd_o.data     = data_byte_i;
    cmd_o.escape   = escape;
    cmd_o.sep      = ppe_pkg::SepNone;
    cmd_o.path_end = 1'b0;
    cmd_o.error    = 1'b0;
    phase_d        = phase_q;
    if (!phase_q && spec_end_i) begin
      cmd_o.error = 1'b1;
      phase_d     = 1'b0;
    end else if (!phase_q) begin
      if (field_end_i) begin
        cmd_o.sep = ppe_pkg::SepEquals;
        phase_d   = 1'b1;
      end
    end else if (field_end_i || spec_end_i) begin
      cmd_o.sep      = ppe_pkg::SepSlash;
      cmd_o.path_end = spec_end_i;
      phase_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (push_o) begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/ppe_queue.sv
`default_nettype none

module ppe_queue #(
  parameter int unsigned Depth = ppe_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ppe_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output ppe_pkg::cmd_t      cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ppe_pkg::cmd_t   entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/ppe_back.sv
`default_nettype none

module ppe_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire ppe_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_o,
  output logic               path_end_o,
  output logic               error_o
);

  ppe_pkg::cmd_t cmd_q;
  logic          active_q;
  logic [1:0]    step_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          last_q;
  logic          path_end_q;
  logic          error_q;

  logic          load;
  logic          emit;
  logic [1:0]    data_last;
  logic [1:0]    final_step;
  logic          is_last;
  logic [7:0]    sep_byte;
  logic [7:0]    cur_byte;
  logic          cur_path_end;

  assign load = !out_valid_q || out_ready_i;
  assign emit = active_q && load;

  // Escaped bytes take steps 0 to 2, plain bytes step 0; a separator, if any, comes last.
  always_comb begin
    data_last  = cmd_q.escape ? 2'd2 : 2'd0;
    final_step = data_last + ((cmd_q.sep != ppe_pkg::SepNone) ? 2'd1 : 2'd0);
    if (cmd_q.error) begin
      final_step = 2'd0;
    end
    is_last = (step_q == final_step);
  end

  always_comb begin
    case (cmd_q.sep)
      ppe_pkg::SepEquals: sep_byte = ppe_pkg::ChEquals;
      ppe_pkg::SepSlash:  sep_byte = ppe_pkg::ChSlash;
      default:            sep_byte = ppe_pkg::ErrByte;
    endcase
  end

  always_comb begin
    cur_path_end = 1'b0;
    if (cmd_q.error) begin
      cur_byte = ppe_pkg::ErrByte;
    end else if (step_q > data_last) begin
      cur_byte     = sep_byte;
      cur_path_end = cmd_q.path_end;
    end else if (!cmd_q.escape) begin
      cur_byte = cmd_q.data;
    end else begin
      case (step_q)
        2'd0:    cur_byte = ppe_pkg::ChPercent;
        2'd1:    cur_byte = ppe_pkg::hex_digit(cmd_q.data[7:4]);
        default: cur_byte = ppe_pkg::hex_digit(cmd_q.data[3:0]);
      endcase
    end
  end

  // The next command is taken while the last byte of the current one leaves.
  assign pop_o = valid_i && (!active_q || (emit && is_last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        step_q   <= 2'd0;
      end else if (emit) begin
        if (is_last) begin
          active_q <= 1'b0;
          step_q   <= 2'd0;
        end else begin
          step_q <= step_q + 2'd1;
        end
      end
      if (load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      out_byte_q <= cur_byte;
      last_q     <= is_last;
      path_end_q <= cur_path_end;
      error_q    <= cmd_q.error;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;
  assign path_end_o  = path_end_q;
  assign error_o     = error_q;

endmodule

`default_nettype wire

// File: sv/partition_path_escape_encoder.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_ready_o  data_byte_i, field_end_i, spec_end_i
// output    out        out_valid_o/out_ready_i out_byte_o, last_o, path_end_o, error_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each input byte yields one to four output bytes, one per cycle while out_ready_i is high:
// one for a plain byte, three for an escaped byte, plus one for a '=' or '/' separator;
// an error is one byte. The output register of the back end sets the rate, and the first
// result passes the command queue, the command register and the output register.
// Reset loads the default escape masks, returns to the key phase and empties the queue.
// Output stalls fill the command queue, which then drops in_ready_o; config writes
// are always taken.

module partition_path_escape_encoder #(
  parameter int unsigned QueueDepth = ppe_pkg::QueueDepthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        field_end_i,
  input  wire logic                        spec_end_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       out_byte_o,
  output logic                             last_o,
  output logic                             path_end_o,
  output logic                             error_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ppe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ppe_pkg::MaskW-1:0]   cfg_data_i
);

  // Front side: classified commands going into the queue.
  logic          push;
  logic          full;
  ppe_pkg::cmd_t front_cmd;

  // Back side: commands leaving the queue.
  logic          queue_valid;
  logic          pop;
  ppe_pkg::cmd_t back_cmd;

  // The front end holds the escape masks and the key/value phase, and turns each
  // input transfer into one command: the byte, whether to escape it, which separator
  // follows, and whether it is an error.
  ppe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .field_end_i (field_end_i),
    .spec_end_i  (spec_end_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  // A short queue decouples classification from byte emission.
  ppe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (back_cmd)
  );

  // The back end steps through each command and emits one byte per cycle unless stalled.
  ppe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .path_end_o  (path_end_o),
    .error_o     (error_o)
  );

endmodule

`default_nettype wire

// File: sv/ppe_checker.sv
`default_nettype none

module ppe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_o,
  input wire logic       path_end_o,
  input wire logic       error_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("output result changed while stalled");

  // An error result stands alone and is no path end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && !path_end_o && (out_byte_o == ppe_pkg::ErrByte))
    else $error("malformed error result");

  // The end of the path is always the closing slash of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && path_end_o |-> last_o && (out_byte_o == ppe_pkg::ChSlash))
    else $error("path end not on a final slash");

  // After a non-final result the next transfer follows the same item, which cannot be
  // an error result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> !(out_valid_o && error_o))
    else $error("error result inside an expansion");

endmodule

bind partition_path_escape_encoder ppe_checker u_ppe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o),
  .path_end_o  (path_end_o),
  .error_o     (error_o)
);

`default_nettype wire
